/* rtl/sgm_pkg.sv */
// Shared types and constants for the Sobel gradient magnitude block.
package sgm_pkg;

	localparam int MAX_LINE = 1024;
	localparam int PIXEL_BITS = 8;
	localparam int COL_BITS = $clog2(MAX_LINE);
	localparam int LEN_BITS = 11;
	localparam int ROW_BITS = 12;
	localparam int MAG_BITS = 9;
	localparam int SUM_BITS = 2 * PIXEL_BITS + 1;
	localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
	localparam int FULL = (1 << PIXEL_BITS) - 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

	localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(640);
	localparam logic [ROW_BITS-1:0] ROWS_RESET = ROW_BITS'(480);

	localparam logic [0:0] REG_LINE_LENGTH = 1'd0;
	localparam logic [0:0] REG_LINE_COUNT = 1'd1;

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_start;
	} sgm_in_t;

	typedef struct packed {
		logic [MAG_BITS-1:0] magnitude;
		logic                position_valid;
		logic                is_border;
	} sgm_out_t;

	// Work handed from the front part to the back part.
	typedef struct packed {
		logic [PIXEL_BITS-1:0] gx;
		logic [PIXEL_BITS-1:0] gy;
		logic                  position_valid;
		logic                  is_border;
	} sgm_job_t;

endpackage

/* rtl/sgm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module sgm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/sgm_front.sv */
// Front part: position counters, line stores, window and clipped Sobel sums.
module sgm_front import sgm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [LEN_BITS-1:0] line_length,
	input  logic [ROW_BITS-1:0] line_count,
	input  logic                in_valid,
	input  sgm_in_t             in_data,
	output logic                busy,
	output logic                job_valid,
	output sgm_job_t            job,
	input  logic                job_ready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_CALC = 2'd2;
	localparam logic [1:0] ST_SEND = 2'd3;

	logic [1:0] state_q;
	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;
	logic [COL_BITS-1:0] col_s1;
	logic [ROW_BITS-1:0] row_s1;
	logic [PIXEL_BITS-1:0] px_s1;
	logic [PIXEL_BITS-1:0] win_q [3][3];
	logic [PIXEL_BITS-1:0] upper_rd;
	logic [PIXEL_BITS-1:0] mid_rd;
	sgm_job_t job_q;

	logic [LEN_BITS-1:0] len_eff;
	logic [ROW_BITS-1:0] lines_eff;
	logic [COL_BITS-1:0] col_start;
	logic [ROW_BITS-1:0] row_start;
	logic [ROW_BITS-1:0] row_wrap;
	logic [COL_BITS-1:0] col_pos;
	logic [ROW_BITS-1:0] row_pos;
	logic [COL_BITS-1:0] col_next;
	logic [ROW_BITS-1:0] row_next;
	logic [ROW_BITS-1:0] row_inc;
	logic pos_valid;
	logic border;
	logic [ROW_BITS-1:0] rep_row;
	logic [COL_BITS-1:0] rep_col;
	logic signed [PIXEL_BITS+3:0] gx_sum;
	logic signed [PIXEL_BITS+3:0] gy_sum;
	logic [PIXEL_BITS-1:0] gx_clip;
	logic [PIXEL_BITS-1:0] gy_clip;
	logic accept;

	assign accept = in_valid && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	always_comb begin
		if (line_length < LEN_BITS'(3)) begin
			len_eff = LEN_BITS'(3);
		end else if (line_length > LEN_BITS'(MAX_LINE)) begin
			len_eff = LEN_BITS'(MAX_LINE);
		end else begin
			len_eff = line_length;
		end
		lines_eff = (line_count < ROW_BITS'(3)) ? ROW_BITS'(3) : line_count;
	end

	// Position of the incoming pixel, wrapped against the current limits.
	always_comb begin
		col_start = in_data.frame_start ? '0 : col_q;
		row_start = in_data.frame_start ? '0 : row_q;
		row_wrap = row_start;
		col_pos = col_start;
		if (LEN_BITS'(col_start) >= len_eff) begin
			col_pos = '0;
			row_wrap = row_start + ROW_BITS'(1);
		end
		row_pos = (row_wrap >= lines_eff) ? '0 : row_wrap;
		col_next = col_pos + COL_BITS'(1);
		row_next = row_pos;
		row_inc = row_pos + ROW_BITS'(1);
		if (LEN_BITS'(col_pos) + LEN_BITS'(1) >= len_eff) begin
			col_next = '0;
			row_next = (row_inc >= lines_eff) ? '0 : row_inc;
		end
	end

	sgm_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_LINE)) u_mid_line (
		.clk  (clk),
		.we   (state_q == ST_READ),
		.waddr(col_s1),
		.wdata(px_s1),
		.re   (accept),
		.raddr(col_pos),
		.rdata(mid_rd)
	);

	sgm_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_LINE)) u_upper_line (
		.clk  (clk),
		.we   (state_q == ST_READ),
		.waddr(col_s1),
		.wdata(mid_rd),
		.re   (accept),
		.raddr(col_pos),
		.rdata(upper_rd)
	);

	always_comb begin
		pos_valid = (row_s1 >= ROW_BITS'(2)) ||
			((row_s1 == ROW_BITS'(1)) && (col_s1 != '0));
		if (col_s1 != '0) begin
			rep_row = row_s1 - ROW_BITS'(1);
			rep_col = col_s1 - COL_BITS'(1);
		end else begin
			rep_row = row_s1 - ROW_BITS'(2);
			rep_col = COL_BITS'(len_eff - LEN_BITS'(1));
		end
		border = pos_valid && ((rep_row == '0) || (rep_row == lines_eff - ROW_BITS'(1)) ||
			(rep_col == '0) || (LEN_BITS'(rep_col) == len_eff - LEN_BITS'(1)));
	end

	// The window has already shifted in the new column when these sums form.
	always_comb begin
		gx_sum = $signed({4'd0, win_q[0][2]}) + $signed({3'd0, win_q[1][2], 1'b0}) +
			$signed({4'd0, win_q[2][2]}) - $signed({4'd0, win_q[0][0]}) -
			$signed({3'd0, win_q[1][0], 1'b0}) - $signed({4'd0, win_q[2][0]});
		gy_sum = $signed({4'd0, win_q[2][0]}) + $signed({3'd0, win_q[2][1], 1'b0}) +
			$signed({4'd0, win_q[2][2]}) - $signed({4'd0, win_q[0][0]}) -
			$signed({3'd0, win_q[0][1], 1'b0}) - $signed({4'd0, win_q[0][2]});
		if (gx_sum <= 0) begin
			gx_clip = '0;
		end else if (gx_sum >= (PIXEL_BITS+4)'(FULL)) begin
			gx_clip = PIXEL_BITS'(FULL);
		end else begin
			gx_clip = gx_sum[PIXEL_BITS-1:0];
		end
		if (gy_sum <= 0) begin
			gy_clip = '0;
		end else if (gy_sum >= (PIXEL_BITS+4)'(FULL)) begin
			gy_clip = PIXEL_BITS'(FULL);
		end else begin
			gy_clip = gy_sum[PIXEL_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						col_q <= col_next;
						row_q <= row_next;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					for (int i = 0; i < 3; i++) begin
						win_q[i][0] <= win_q[i][1];
						win_q[i][1] <= win_q[i][2];
					end
					win_q[0][2] <= upper_rd;
					win_q[1][2] <= mid_rd;
					win_q[2][2] <= px_s1;
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (job_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= col_pos;
			row_s1 <= row_pos;
			px_s1 <= in_data.pixel;
		end
		if (state_q == ST_CALC) begin
			job_q.position_valid <= pos_valid;
			job_q.is_border <= border;
			job_q.gx <= (pos_valid && !border) ? gx_clip : '0;
			job_q.gy <= (pos_valid && !border) ? gy_clip : '0;
		end
	end

	assign job_valid = (state_q == ST_SEND);
	assign job = job_q;

	a_read_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_READ))
		else $error("front did not step to the read state after a request");

	a_job_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && !job_ready) |=> (job_valid && $stable(job_q)))
		else $error("stalled job changed");

	a_border_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && job.is_border) |-> job.position_valid)
		else $error("border flag on an unreached position");

endmodule

/* rtl/sgm_queue.sv */
// Short queue of jobs between the front and back parts.
module sgm_queue import sgm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	input  sgm_job_t wr_data,
	output logic     wr_ready,
	output logic     rd_valid,
	output sgm_job_t rd_data,
	input  logic     rd_ready
);

	sgm_job_t slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wptr_q;
	logic [QPTR_BITS-1:0] rptr_q;
	logic [QPTR_BITS:0] count_q;
	logic do_wr;
	logic do_rd;

	assign wr_ready = (count_q != (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data = slot_q[rptr_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + QPTR_BITS'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + QPTR_BITS'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (QPTR_BITS+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (QPTR_BITS+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_BITS+1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

/* rtl/sgm_back.sv */
// Back part: sum of squares and a bit-serial integer square root.
module sgm_back import sgm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_valid,
	input  sgm_job_t job,
	output logic     job_ready,
	output logic     busy,
	output logic     res_valid,
	output sgm_out_t res,
	input  logic     res_ready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SQR = 2'd1;
	localparam logic [1:0] ST_ROOT = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;
	localparam int STEP_BITS = $clog2(ROOT_BITS + 1);

	logic [1:0] state_q;
	logic [PIXEL_BITS-1:0] gx_q;
	logic [PIXEL_BITS-1:0] gy_q;
	logic valid_q;
	logic border_q;
	logic [2*PIXEL_BITS-1:0] sqx_q;
	logic [2*PIXEL_BITS-1:0] sqy_q;
	logic [2*ROOT_BITS-1:0] rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [2*ROOT_BITS-1:0] rad_q;
	logic [STEP_BITS-1:0] step_q;
	logic out_full_q;
	sgm_out_t out_q;

	logic [ROOT_BITS+1:0] trial;
	logic [ROOT_BITS+1:0] rem_top;
	logic [ROOT_BITS+1:0] rem_sub;
	logic out_load;

	// One result bit per cycle: restoring square root on two radicand bits.
	always_comb begin
		rem_top = {rem_q[ROOT_BITS-1:0], rad_q[2*ROOT_BITS-1 -: 2]};
		trial = {root_q, 2'b01};
		rem_sub = rem_top - trial;
	end

	assign job_ready = (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE) || out_full_q;
	assign res_valid = out_full_q;
	assign res = out_q;
	assign out_load = (state_q == ST_DONE) && (!out_full_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_full_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_full_q <= 1'b1;
			end else if (res_valid && res_ready) begin
				out_full_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (step_q == STEP_BITS'(ROOT_BITS)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					gx_q <= job.gx;
					gy_q <= job.gy;
					valid_q <= job.position_valid;
					border_q <= job.is_border;
				end
			end
			ST_SQR: begin
				sqx_q <= (2*PIXEL_BITS)'(gx_q) * (2*PIXEL_BITS)'(gx_q);
				sqy_q <= (2*PIXEL_BITS)'(gy_q) * (2*PIXEL_BITS)'(gy_q);
				rad_q <= '0;
				rem_q <= '0;
				root_q <= '0;
				step_q <= '0;
			end
			ST_ROOT: begin
				if (step_q == '0) begin
					rad_q <= (2*ROOT_BITS)'({1'b0, sqx_q} + {1'b0, sqy_q});
				end else begin
					rad_q <= rad_q << 2;
					if (!rem_sub[ROOT_BITS+1]) begin
						rem_q <= (2*ROOT_BITS)'(rem_sub);
						root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
					end else begin
						rem_q <= (2*ROOT_BITS)'(rem_top);
						root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
					end
				end
				step_q <= step_q + STEP_BITS'(1);
			end
			ST_DONE: begin
				if (out_load) begin
					out_q.magnitude <= MAG_BITS'(root_q);
					out_q.position_valid <= valid_q;
					out_q.is_border <= border_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_done_after_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQR) |=> (state_q == ST_ROOT))
		else $error("back skipped the root steps");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(out_q)))
		else $error("waiting result changed");

endmodule

/* rtl/sobel_gradient_magnitude.sv */
// Top level of the Sobel gradient magnitude block with its register port.
// Each pixel request passes through the front part as line store read, window shift, Sobel
// sums and hand-off, and the front takes no new pixel until the last one is handed off; the
// back part then takes each request through the squares of the sums, a one-bit-per-cycle
// square root and the result hand-off, and takes no new request until its result is loaded
// for hand-off, while a four-entry job queue lets the two parts stall separately. Every
// pixel gives one result for the position one line and one pixel behind it; the line stores
// need no clearing. The user must write the registers only while no request is in flight;
// the block itself does not enforce it.
module sobel_gradient_magnitude import sgm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	input  sgm_in_t     in_item,
	output logic        full,
	output logic        empty,
	input  logic        pop,
	output sgm_out_t    out_item
);

	logic [LEN_BITS-1:0] line_length_q;
	logic [ROW_BITS-1:0] line_count_q;
	logic front_busy;
	logic back_busy;
	logic fj_valid;
	logic fj_ready;
	sgm_job_t fj;
	logic bj_valid;
	logic bj_ready;
	sgm_job_t bj;
	logic res_valid;
	logic reg_wr;
	logic [0:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[2:2];
	assign reg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LEN_RESET;
			line_count_q <= ROWS_RESET;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_LINE_LENGTH: line_length_q <= pwdata[LEN_BITS-1:0];
				REG_LINE_COUNT:  line_count_q <= pwdata[ROW_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LINE_LENGTH: prdata = 32'(line_length_q);
			REG_LINE_COUNT:  prdata = 32'(line_count_q);
			default:         prdata = '0;
		endcase
	end

	assign full = front_busy;
	assign empty = !res_valid;

	sgm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_length(line_length_q),
		.line_count (line_count_q),
		.in_valid   (push),
		.in_data    (in_item),
		.busy       (front_busy),
		.job_valid  (fj_valid),
		.job        (fj),
		.job_ready  (fj_ready)
	);

	sgm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(fj_valid),
		.wr_data (fj),
		.wr_ready(fj_ready),
		.rd_valid(bj_valid),
		.rd_data (bj),
		.rd_ready(bj_ready)
	);

	sgm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(bj_valid),
		.job      (bj),
		.job_ready(bj_ready),
		.busy     (back_busy),
		.res_valid(res_valid),
		.res      (out_item),
		.res_ready(pop)
	);

	a_pop_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty) |-> back_busy)
		else $error("result taken while back part reports nothing held");

endmodule
